// File: rtl/sdaf_pkg.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII formatter package
// Shared constants and types for the formatter and its divide-by-ten unit.
// ----------------------------------------------------------------------------
package sdaf_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned COUNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned INDEX_W    = $clog2(MAX_DIGITS);

  // floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every 32-bit n.
  localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Result of one pass through the divide-by-ten unit.
  typedef struct packed {
    logic [VALUE_W-1:0] quotient;
    digit_t             remainder;
  } div_result_t;

endpackage

// File: rtl/signed_decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII formatter
// Turns one signed 32-bit integer into its decimal text, one character per
// output transaction, most significant character first.
// ----------------------------------------------------------------------------
// One number is taken at a time. Its magnitude is split into digits by a
// single registered multiply-by-reciprocal divide-by-ten unit, through a
// load state and a divide state per digit, least significant digit first,
// into a ten-entry digit buffer. The text is then sent from the buffer at one
// character per cycle while the sink is ready: '-' first for a negative
// number, then the digits, with tlast on the final digit. The last character
// may still wait in the output register while the next number is taken.
module signed_decimal_ascii_formatter import sdaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value (signed)
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,   // [7:0] character
  output logic              out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic                neg_r;
  logic                sign_pend_r;
  logic [VALUE_W-1:0]  mag_r;
  logic [COUNT_W-1:0]  ndig_r;
  logic [INDEX_W-1:0]  idx_r;
  digit_t              digit_r [MAX_DIGITS];
  logic                out_tvalid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic                in_accept;
  logic                out_free;
  logic                div_load;
  div_result_t         div_res;
  logic [INDEX_W-1:0]  wr_idx;
  logic                div_done;

  sdaf_div10 u_div10 (
    .clk      (clk),
    .load     (div_load),
    .dividend (mag_r),
    .result   (div_res)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign div_load  = (state_r == ST_MUL);
  assign wr_idx    = ndig_r[INDEX_W-1:0];
  assign div_done  = (div_res.quotient == '0) ||
                     (ndig_r == COUNT_W'(MAX_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      digit_r[wr_idx] <= div_res.remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      sign_pend_r  <= 1'b0;
    end else begin
      // While emitting, a taken character is always replaced in the same cycle.
      if (out_tvalid_r && out_tready && (state_r != ST_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            neg_r   <= in_tdata[VALUE_W-1];
            mag_r   <= in_tdata[VALUE_W-1] ? (~in_tdata + VALUE_W'(1)) : in_tdata;
            ndig_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          mag_r  <= div_res.quotient;
          ndig_r <= ndig_r + COUNT_W'(1);
          if (div_done) begin
            idx_r       <= wr_idx;
            sign_pend_r <= neg_r;
            state_r     <= ST_EMIT;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            if (sign_pend_r) begin
              out_char_r  <= ASCII_MINUS;
              out_last_r  <= 1'b0;
              sign_pend_r <= 1'b0;
            end else begin
              out_char_r <= ASCII_ZERO + CHAR_W'(digit_r[idx_r]);
              out_last_r <= (idx_r == '0);
              if (idx_r == '0) begin
                state_r <= ST_IDLE;
              end else begin
                idx_r <= idx_r - INDEX_W'(1);
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // The reciprocal divide must always leave a proper decimal digit.
  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_res.remainder <= digit_t'(9)))
    else $error("divide-by-ten remainder out of range");

  // The read pointer never runs past the digits collected for this number.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (COUNT_W'(idx_r) < ndig_r))
    else $error("digit read index beyond digit count");

  // The final character of a number is always a digit, never the sign.
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata != ASCII_MINUS))
    else $error("last flag set on a sign character");

  // Acceptance starts a fresh conversion with an empty digit buffer.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_MUL) && (ndig_r == '0))
    else $error("conversion did not start cleanly");

endmodule

// File: rtl/sdaf_div10.sv
// ----------------------------------------------------------------------------
// Divide-by-ten unit
// Registers the reciprocal product of the loaded operand; quotient and
// remainder are valid in the cycle after a load.
// ----------------------------------------------------------------------------
module sdaf_div10 import sdaf_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [VALUE_W-1:0] dividend,
  output div_result_t        result
);

  logic [VALUE_W-1:0]   dividend_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [2*VALUE_W-1:0] prod_nxt;
  logic [VALUE_W-1:0]   quot_ext;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;

  assign prod_nxt = (2*VALUE_W)'(dividend) * (2*VALUE_W)'(RECIP10);

  always_ff @(posedge clk) begin
    if (load) begin
      dividend_r <= dividend;
      quot_r     <= prod_nxt[2*VALUE_W-1:RECIP_SHIFT];
    end
  end

  // The remainder is n - 10*q, with 10*q formed as 8*q + 2*q.
  assign quot_ext = VALUE_W'(quot_r);
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full = dividend_r - quot_x10;

  assign result.quotient  = quot_ext;
  assign result.remainder = rem_full[DIGIT_W-1:0];

endmodule
